/* hdl/sma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_pkg
// Shared widths, reset values and status types of the moving average
// oscillator.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int PRICE_W  = 32;
  localparam int OSC_W    = 33;
  localparam int PERIOD_W = 9;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 9'd30;

  // window status for the word just taken
  typedef struct packed {
    logic remove;  // oldest price leaves the window
    logic full;    // window holds period prices after this word
  } win_stat_t;

endpackage

`default_nettype wire

/* hdl/sma_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_in_if
// Price word channel: valid/ready handshake with price and series start.
// ----------------------------------------------------------------------------
interface sma_in_if;
  import sma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [PRICE_W-1:0]  price;
  logic                       series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink   (input valid, input price, input series_start, output ready);

endinterface

`default_nettype wire

/* hdl/sma_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_out_if
// Result word channel: valid/ready handshake with oscillator and valid flag.
// ----------------------------------------------------------------------------
interface sma_out_if;
  import sma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OSC_W-1:0]  oscillator;
  logic                     valid_res;

  modport source (output valid, output oscillator, output valid_res, input ready);
  modport sink   (input valid, input oscillator, input valid_res, output ready);

endinterface

`default_nettype wire

/* hdl/sma_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sma_div #(
  parameter int DW = 40,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW);

  logic [DW-1:0]   quo_r, quo_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [VW:0]     shifted;
  logic [VW:0]     trial;

  always_comb begin
    shifted  = {rem_r, quo_r[DW-1]};
    trial    = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restore when the trial subtract goes negative
      if (!trial[VW]) begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* hdl/sma_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_window
// Circular price window: memory, write pointer and fill count. Reads the
// price that leaves a full window while the new price is written.
// ----------------------------------------------------------------------------
module sma_window #(
  parameter int MAX_PERIOD = 256,
  parameter int CW         = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          take,
  input  logic                          series_start,
  input  logic [sma_pkg::PRICE_W-1:0]   price,
  input  logic [CW-1:0]                 period,
  output logic [sma_pkg::PRICE_W-1:0]   old_data,
  output sma_pkg::win_stat_t            stat
);
  import sma_pkg::*;

  localparam int PTRW = $clog2(MAX_PERIOD);

  logic [PRICE_W-1:0] mem [MAX_PERIOD];
  logic [PRICE_W-1:0] rd_data_r;
  logic [PTRW-1:0]    wp_r, wp_nxt, wp_base;
  logic [CW-1:0]      fill_r, fill_nxt, fill_base;
  win_stat_t          stat_r, stat_nxt;
  logic [CW:0]        wp_ext;
  logic [CW:0]        old_ext;
  logic [PTRW-1:0]    old_idx;

  always_comb begin
    wp_base   = series_start ? '0 : wp_r;
    fill_base = series_start ? '0 : fill_r;
    wp_nxt    = (wp_base == PTRW'(MAX_PERIOD - 1)) ? '0 : wp_base + PTRW'(1);
    fill_nxt  = (fill_base < period) ? fill_base + CW'(1) : fill_base;

    // slot of the price written period words ago
    wp_ext  = (CW + 1)'(wp_r);
    if (wp_ext >= {1'b0, period}) begin
      old_ext = wp_ext - {1'b0, period};
    end else begin
      old_ext = wp_ext + (CW + 1)'(MAX_PERIOD) - {1'b0, period};
    end
    old_idx = old_ext[PTRW-1:0];

    stat_nxt.remove = !series_start && (fill_r >= period);
    stat_nxt.full   = (fill_nxt == period);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      stat_r <= '0;
    end else if (clear) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (take) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      stat_r <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mem[wp_base] <= price;
    end
  end

  // separate read port: sees the value before this cycle's write
  always_ff @(posedge clk) begin
    if (take) begin
      rd_data_r <= mem[old_idx];
    end
  end

  assign old_data = rd_data_r;
  assign stat     = stat_r;

endmodule

`default_nettype wire

/* hdl/sma_oscillator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_oscillator
// Price minus the moving average of the last period prices, Q16.16.
// ----------------------------------------------------------------------------
// Sequence: an accepted word passes S_SUB, then with a full window S_NORM
//   and S_DIV, where the bit-serial divider runs, then S_HOLD; a word before
//   the window is full goes from S_SUB straight to S_HOLD.
// Input: the next word can be taken the cycle after the result is loaded;
//   a result held on the output delays that load.
// Reset: period 30, window empty, sum zero; window memory is not cleared.
// ----------------------------------------------------------------------------
module sma_oscillator #(
  parameter int MAX_PERIOD = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sma_in_if.sink                         in_ch,
  sma_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sma_pkg::PERIOD_W-1:0]   cfg_data
);
  import sma_pkg::*;

  localparam int CW = $clog2(MAX_PERIOD + 1);
  localparam int SW = PRICE_W + $clog2(MAX_PERIOD);
  localparam int PW = (CW > PERIOD_W) ? CW : PERIOD_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUB  = 5'b00010,
    S_NORM = 5'b00100,
    S_DIV  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [PW-1:0]       per_ext;
  logic [CW-1:0]       p_eff;
  logic signed [PRICE_W-1:0] price_r;
  logic signed [SW-1:0]      sum_r, sum_nxt;
  logic                neg_r;
  logic                take;
  logic [PRICE_W-1:0]  old_data;
  win_stat_t           stat;
  logic                div_start;
  logic                div_done;
  logic [SW-1:0]       div_q;
  logic [SW-1:0]       sum_mag;
  logic signed [OSC_W-1:0] mean;
  logic signed [OSC_W-1:0] osc;
  logic                out_load;
  logic                out_valid_r;
  logic signed [OSC_W-1:0] out_osc_r;
  logic                out_res_r;

  // period zero acts as one, large periods saturate
  always_comb begin
    per_ext = PW'(period_r);
    if (per_ext == '0) begin
      p_eff = CW'(1);
    end else if (per_ext > PW'(MAX_PERIOD)) begin
      p_eff = CW'(MAX_PERIOD);
    end else begin
      p_eff = per_ext[CW-1:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign take        = in_ch.valid && in_ch.ready;

  sma_window #(
    .MAX_PERIOD (MAX_PERIOD),
    .CW         (CW)
  ) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (cfg_we),
    .take         (take),
    .series_start (in_ch.series_start),
    .price        (in_ch.price),
    .period       (p_eff),
    .old_data     (old_data),
    .stat         (stat)
  );

  assign sum_mag   = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign div_start = (state_r == S_NORM);

  sma_div #(
    .DW (SW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (p_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // quotient magnitude stays below 2^32, sign restored for truncation to zero
  assign mean = neg_r ? -$signed(div_q[OSC_W-1:0]) : $signed(div_q[OSC_W-1:0]);
  assign osc  = $signed({price_r[PRICE_W-1], price_r}) - mean;

  assign out_load = (state_r == S_HOLD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          sum_nxt = (in_ch.series_start ? '0 : sum_r)
                    + SW'(in_ch.price);
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        if (stat.remove) begin
          sum_nxt = sum_r - SW'($signed(old_data));
        end
        state_nxt = stat.full ? S_NORM : S_HOLD;
      end
      S_NORM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RST;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        period_r <= cfg_data;
        sum_r    <= '0;
      end else begin
        sum_r <= sum_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      price_r <= in_ch.price;
    end
    if (div_start) begin
      neg_r <= sum_r[SW-1];
    end
    if (out_load) begin
      out_res_r <= stat.full;
      out_osc_r <= stat.full ? osc : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.oscillator = out_osc_r;
  assign out_ch.valid_res  = out_res_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

  // an accepted word blocks the input on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_ch.ready)
    else $error("input ready right after accept");

  // a word that is not yet averaged carries a zero oscillator
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.valid_res) |-> (out_ch.oscillator == '0))
    else $error("nonzero oscillator on invalid result");

  // a result waiting on the output is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_osc_r))
    else $error("pending result changed");

endmodule

`default_nettype wire
